### rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared widths, word types and limits for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int EW         = 16;
    localparam int FRAC_SHIFT = 24;
    localparam int PW         = 2 * EW;
    localparam int CW         = 2 * EW + 1;
    localparam int DPW        = EW + CW;
    localparam int DETW       = 3 * EW + 3;
    localparam int MAGW       = 3 * EW;
    localparam int NUMW       = 2 * EW + FRAC_SHIFT;
    localparam int OUTW       = 32;
    localparam int NLANES     = 9;

    localparam logic [NUMW:0]   POS_LIM = (NUMW+1)'(33'h0_7FFF_FFFF);
    localparam logic [NUMW:0]   NEG_LIM = (NUMW+1)'(33'h0_8000_0000);
    localparam logic [OUTW-1:0] POS_SAT = 32'h7FFF_FFFF;
    localparam logic [OUTW-1:0] NEG_SAT = 32'h8000_0000;

    typedef logic signed [EW-1:0]   elem_t;
    typedef logic signed [OUTW-1:0] res_elem_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } in_word_t;

    typedef struct packed {
        res_elem_t b00;
        res_elem_t b01;
        res_elem_t b02;
        res_elem_t b10;
        res_elem_t b11;
        res_elem_t b12;
        res_elem_t b20;
        res_elem_t b21;
        res_elem_t b22;
        logic      singular;
        logic      saturated;
    } out_word_t;

    typedef struct packed {
        logic [OUTW-1:0] val;
        logic            sat;
    } lane_res_t;

endpackage

### rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 inverse by the adjugate: nine cofactor lanes, a shared determinant,
// nine pipelined divider lanes and a merging output register.
// pipeline: 64 register stages from the input register to out_valid
// (input 1, cofactor 2, determinant 2, setup 1, divide 56, round 1, output 1)
// throughput: one word per cycle; the whole pipeline holds when the output stalls
// reset: rst_n clears only the valid bits of the pipeline
// ----------------------------------------------------------------------------
module matrix3x3_inverse
    import m3inv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int LAT = 6 + NUMW + 2;

    logic                en;
    logic [LAT-1:0]      v_reg;
    logic [LAT-1:0]      v_next;
    in_word_t            in_reg;
    elem_t               a [3][3];
    elem_t               row0_d1_reg [3];
    elem_t               row0_d2_reg [3];
    logic signed [CW-1:0] cof_w [3][3];
    logic signed [CW-1:0] cof_d3_reg [3][3];
    logic signed [CW-1:0] cof_d4_reg [3][3];
    logic signed [DPW-1:0] dp_reg [3];
    logic signed [DETW-1:0] det_reg;
    logic signed [DETW-1:0] det_next;
    logic [DETW-1:0]     det_abs;
    logic [NUMW:0][MAGW-1:0] dpipe_reg;
    logic [NUMW+1:0]     sing_reg;
    lane_res_t           res_o [NLANES];

    assign en       = ~v_reg[LAT-1] | out_ready;
    assign in_ready = en;
    assign v_next   = {v_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_comb
    begin
        a[0][0] = in_reg.a00;
        a[0][1] = in_reg.a01;
        a[0][2] = in_reg.a02;
        a[1][0] = in_reg.a10;
        a[1][1] = in_reg.a11;
        a[1][2] = in_reg.a12;
        a[2][0] = in_reg.a20;
        a[2][1] = in_reg.a21;
        a[2][2] = in_reg.a22;
    end

    genvar r, c;
    generate
        for (r = 0; r < 3; r++)
        begin : g_row
            for (c = 0; c < 3; c++)
            begin : g_col
                localparam int R0 = (r == 0) ? 1 : 0;
                localparam int R1 = (r == 2) ? 1 : 2;
                localparam int C0 = (c == 0) ? 1 : 0;
                localparam int C1 = (c == 2) ? 1 : 2;

                m3inv_cof #(
                    .NEG (((r + c) % 2) == 1)
                ) u_cof (
                    .clk (clk),
                    .en  (en),
                    .p   (a[R0][C0]),
                    .q   (a[R0][C1]),
                    .r   (a[R1][C0]),
                    .s   (a[R1][C1]),
                    .cof (cof_w[r][c])
                );

                m3inv_div u_div (
                    .clk     (clk),
                    .en      (en),
                    .cof     (cof_d4_reg[r][c]),
                    .det_neg (det_reg[DETW-1]),
                    .dpipe   (dpipe_reg),
                    .res     (res_o[c*3+r])
                );
            end
        end
    endgenerate

    always_comb
    begin
        det_next = DETW'(dp_reg[0]) + DETW'(dp_reg[1]) + DETW'(dp_reg[2]);
        det_abs  = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= in_word;
            for (int j = 0; j < 3; j++)
            begin
                row0_d1_reg[j] <= a[0][j];
                row0_d2_reg[j] <= row0_d1_reg[j];
                dp_reg[j]      <= row0_d2_reg[j] * cof_w[0][j];
            end
            cof_d3_reg   <= cof_w;
            cof_d4_reg   <= cof_d3_reg;
            det_reg      <= det_next;
            dpipe_reg[0] <= det_abs[MAGW-1:0];
            for (int k = 1; k <= NUMW; k++)
                dpipe_reg[k] <= dpipe_reg[k-1];
            sing_reg <= {sing_reg[NUMW:0], (det_reg == '0)};
        end
    end

    m3inv_merge u_merge (
        .clk  (clk),
        .en   (en),
        .res  (res_o),
        .sing (sing_reg[NUMW+1]),
        .word (out_word)
    );

    assign out_valid = v_reg[LAT-1];

    a_sing_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.singular |-> !out_word.saturated && out_word.b00 == '0
            && out_word.b11 == '0 && out_word.b22 == '0)
        else $error("singular word carries nonzero data");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted word not in first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(v_reg))
        else $error("pipeline moved during output stall");

endmodule

### rtl/m3inv_cof.sv
// ----------------------------------------------------------------------------
// m3inv_cof
// One cofactor lane: two products, difference and checkerboard sign.
// ----------------------------------------------------------------------------
module m3inv_cof
    import m3inv_pkg::*;
#(
    parameter bit NEG = 1'b0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  elem_t                p,
    input  elem_t                q,
    input  elem_t                r,
    input  elem_t                s,
    output logic signed [CW-1:0] cof
);

    logic signed [PW-1:0] m0_reg;
    logic signed [PW-1:0] m1_reg;
    logic signed [CW-1:0] cof_reg;
    logic signed [CW-1:0] cof_next;
    logic signed [CW-1:0] diff;

    always_comb
    begin
        diff     = CW'(m0_reg) - CW'(m1_reg);
        cof_next = NEG ? -diff : diff;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg  <= p * s;
            m1_reg  <= q * r;
            cof_reg <= cof_next;
        end
    end

    assign cof = cof_reg;

endmodule

### rtl/m3inv_div.sv
// ----------------------------------------------------------------------------
// m3inv_div
// One divider lane: restoring division one quotient bit per stage,
// then rounding half away from zero and saturation to Q8.24.
// ----------------------------------------------------------------------------
module m3inv_div
    import m3inv_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [CW-1:0]       cof,
    input  logic                       det_neg,
    input  logic [NUMW:0][MAGW-1:0]    dpipe,
    output lane_res_t                  res
);

    logic [MAGW-1:0] rem_reg [NUMW+1];
    logic [NUMW-1:0] sh_reg  [NUMW+1];
    logic            neg_reg [NUMW+1];
    lane_res_t       res_reg;
    lane_res_t       res_next;

    logic [CW-1:0]   mag;
    logic            rnd;
    logic [NUMW:0]   q_r;
    logic            ovf;
    logic [OUTW-1:0] q_lo;

    always_comb
    begin
        mag = cof[CW-1] ? CW'(-cof) : CW'(cof);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            sh_reg[0]  <= {mag[PW-1:0], {FRAC_SHIFT{1'b0}}};
            neg_reg[0] <= cof[CW-1] ^ det_neg;
        end
    end

    genvar i;
    generate
        for (i = 1; i <= NUMW; i++)
        begin : g_stage
            logic [MAGW:0]   t;
            logic            ge;
            logic [MAGW-1:0] rem_next;
            logic [NUMW-1:0] sh_next;

            always_comb
            begin
                t        = {rem_reg[i-1], sh_reg[i-1][NUMW-1]};
                ge       = t >= {1'b0, dpipe[i-1]};
                rem_next = ge ? MAGW'(t - {1'b0, dpipe[i-1]}) : MAGW'(t);
                sh_next  = {sh_reg[i-1][NUMW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    sh_reg[i]  <= sh_next;
                    neg_reg[i] <= neg_reg[i-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        rnd  = {rem_reg[NUMW], 1'b0} >= {1'b0, dpipe[NUMW]};
        q_r  = {1'b0, sh_reg[NUMW]} + (NUMW+1)'(rnd);
        ovf  = neg_reg[NUMW] ? (q_r > NEG_LIM) : (q_r > POS_LIM);
        q_lo = q_r[OUTW-1:0];
        res_next.sat = ovf;
        if (ovf)
            res_next.val = neg_reg[NUMW] ? NEG_SAT : POS_SAT;
        else
            res_next.val = neg_reg[NUMW] ? OUTW'(-q_lo) : q_lo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/m3inv_merge.sv
// ----------------------------------------------------------------------------
// m3inv_merge
// Output register: gathers the nine lanes, applies the singular case and
// combines the saturation flags.
// ----------------------------------------------------------------------------
module m3inv_merge
    import m3inv_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  lane_res_t res [NLANES],
    input  logic      sing,
    output out_word_t word
);

    out_word_t       word_reg;
    out_word_t       word_next;
    logic [OUTW-1:0] v [NLANES];
    logic            any_sat;

    always_comb
    begin
        any_sat = 1'b0;
        for (int k = 0; k < NLANES; k++)
        begin
            v[k]    = sing ? '0 : res[k].val;
            any_sat = any_sat | res[k].sat;
        end
        word_next.b00       = v[0];
        word_next.b01       = v[1];
        word_next.b02       = v[2];
        word_next.b10       = v[3];
        word_next.b11       = v[4];
        word_next.b12       = v[5];
        word_next.b20       = v[6];
        word_next.b21       = v[7];
        word_next.b22       = v[8];
        word_next.singular  = sing;
        word_next.saturated = any_sat & ~sing;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### sim/matrix3x3_inverse_checker.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker
// Watches both channels of the 3x3 inverse, predicts the adjugate inverse
// of every accepted matrix word and compares each result word in order.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker
    import m3inv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    output int        pending,
    output int        fails
);
    timeunit 1ns;
    timeprecision 1ps;

    out_word_t inverse_q[$];

    function automatic out_word_t predict_inverse(in_word_t w);
        longint m [3][3];
        longint det, p, num, an, ad, q, rem;
        logic [OUTW-1:0] b [3][3];
        logic sat;
        int r0, r1, c0, c1;
        out_word_t o;
        m[0][0] = w.a00; m[0][1] = w.a01; m[0][2] = w.a02;
        m[1][0] = w.a10; m[1][1] = w.a11; m[1][2] = w.a12;
        m[2][0] = w.a20; m[2][1] = w.a21; m[2][2] = w.a22;
        det = m[0][0]*m[1][1]*m[2][2] + m[0][1]*m[1][2]*m[2][0]
            + m[0][2]*m[1][0]*m[2][1] - m[0][0]*m[1][2]*m[2][1]
            - m[0][1]*m[1][0]*m[2][2] - m[0][2]*m[1][1]*m[2][0];
        o = '0;
        if (det == 0)
        begin
            o.singular = 1'b1;
            return o;
        end
        sat = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                r0 = (r == 0) ? 1 : 0;
                r1 = (r == 2) ? 1 : 2;
                c0 = (c == 0) ? 1 : 0;
                c1 = (c == 2) ? 1 : 2;
                p = m[r0][c0]*m[r1][c1] - m[r0][c1]*m[r1][c0];
                if ((r + c) % 2 == 1)
                    p = -p;
                num = p <<< FRAC_SHIFT;
                an = (num < 0) ? -num : num;
                ad = (det < 0) ? -det : det;
                q = an / ad;
                rem = an % ad;
                if (2 * rem >= ad)
                    q++;
                if (q == 0)
                    b[c][r] = '0;
                else if ((num < 0) == (det < 0))
                begin
                    if (q > 64'h7FFF_FFFF)
                    begin
                        b[c][r] = POS_SAT;
                        sat = 1'b1;
                    end
                    else
                        b[c][r] = q[OUTW-1:0];
                end
                else
                begin
                    if (q > 64'h8000_0000)
                    begin
                        b[c][r] = NEG_SAT;
                        sat = 1'b1;
                    end
                    else
                        b[c][r] = -q[OUTW-1:0];
                end
            end
        end
        o.b00 = b[0][0]; o.b01 = b[0][1]; o.b02 = b[0][2];
        o.b10 = b[1][0]; o.b11 = b[1][1]; o.b12 = b[1][2];
        o.b20 = b[2][0]; o.b21 = b[2][1]; o.b22 = b[2][2];
        o.saturated = sat;
        return o;
    endfunction

    function automatic void compare_word(out_word_t exp_w, out_word_t act_w);
        string names [9] = '{"b00", "b01", "b02", "b10", "b11", "b12", "b20", "b21", "b22"};
        logic [OUTW-1:0] e, a;
        for (int i = 0; i < 9; i++)
        begin
            e = exp_w[2 + OUTW*(8-i) +: OUTW];
            a = act_w[2 + OUTW*(8-i) +: OUTW];
            if (e !== a)
            begin
                $error("%s expected %h actual %h", names[i], e, a);
                fails++;
            end
        end
        if (exp_w.singular !== act_w.singular)
        begin
            $error("singular expected %b actual %b", exp_w.singular, act_w.singular);
            fails++;
        end
        if (exp_w.saturated !== act_w.saturated)
        begin
            $error("saturated expected %b actual %b", exp_w.saturated, act_w.saturated);
            fails++;
        end
    endfunction

    initial
    begin
        fails = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                inverse_q.push_back(predict_inverse(in_word));
            if (out_valid && out_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fails++;
                end
                else
                    compare_word(inverse_q.pop_front(), out_word);
            end
            pending = inverse_q.size();
        end
    end

endmodule

### sim/matrix3x3_inverse_tb.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Drives directed and random matrices through the 3x3 inverse with bursty
// input and a stalling output; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;
    import m3inv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1130;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;
    int        pending;
    int        fails;
    int        accepted;
    int        burst_left;

    matrix3x3_inverse uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    matrix3x3_inverse_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .pending   (pending),
        .fails     (fails)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("[matrix3x3_inverse] ERROR");
        $finish;
    end

    function automatic in_word_t make_matrix(elem_t e [9]);
        in_word_t w;
        w = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return w;
    endfunction

    function automatic elem_t rand_elem(int mode);
        case (mode)
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 1024) - 512);
            2: return elem_t'($urandom_range(0, 16) - 8);
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic in_word_t rand_matrix();
        elem_t e [9];
        int mode, kind, src, dst;
        mode = $urandom_range(0, 3);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            e[i] = (mode == 3 && $urandom_range(0, 1)) ? rand_elem(0) : rand_elem(mode);
        if (kind == 0)
        begin
            // repeated row gives a zero determinant
            src = $urandom_range(0, 2);
            dst = (src + 1) % 3;
            for (int c = 0; c < 3; c++)
                e[dst*3 + c] = e[src*3 + c];
        end
        else if (kind == 1)
        begin
            src = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++)
                e[r*3 + src] = '0;
        end
        return make_matrix(e);
    endfunction

    task automatic send_word(in_word_t w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        accepted++;
        burst_left--;
    endtask

    // output stall pattern, with long hold-offs while accepted is between 300 and 320 to fill the pipeline
    initial
    begin
        int mode;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                if (accepted > 300 && accepted < 320)
                begin
                    out_ready <= 1'b0;
                    repeat (400) @(posedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 3) != 0;
                    2: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= $urandom_range(0, 4) == 0;
                endcase
            end
        end
    end

    initial
    begin
        elem_t e [9];
        in_valid   <= 1'b0;
        in_word    <= '0;
        accepted   = 0;
        burst_left = 0;
        rst_n      <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        e = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
        send_word(make_matrix(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_word(make_matrix(e));
        e = '{default: 16'sh7FFF};
        send_word(make_matrix(e));
        e = '{default: 16'sh8000};
        send_word(make_matrix(e));
        e = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        send_word(make_matrix(e));
        e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_word(make_matrix(e));
        e = '{16'sh8000, 16'sh7FFF, 0, 16'sh7FFF, 16'sh8000, 0, 0, 0, 16'sh7FFF};
        send_word(make_matrix(e));
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_word(make_matrix(e));
        e = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
        send_word(make_matrix(e));
        // near-singular blocks push the quotient past the output range
        e = '{16'sh7FFF, 16'sh7FFE, 0, 16'sh7FFE, 16'sh7FFD, 0, 0, 0, 1};
        send_word(make_matrix(e));
        e = '{16'sh7FFF, 16'sh7FFE, 0, 16'sh7FFE, 16'sh7FFD, 0, 0, 0, -1};
        send_word(make_matrix(e));
        e = '{3, 0, 0, 0, 3, 0, 0, 0, 3};
        send_word(make_matrix(e));
        e = '{16'sh0200, 0, 0, 0, 16'sh0200, 0, 0, 0, 16'sh0200};
        send_word(make_matrix(e));
        e = '{1, 2, 3, 4, 5, 6, 7, 8, 9};
        send_word(make_matrix(e));
        e = '{2, 1, 1, 1, 3, 2, 1, 0, 0};
        send_word(make_matrix(e));
        e = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0};
        send_word(make_matrix(e));
        e = '{-5, 7, 1, 3, -2, 4, 6, 1, -8};
        send_word(make_matrix(e));
        e = '{16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0, 16'sh3333, 16'shCCCC,
              16'sh00FF, 16'shFF00, 16'sh1234};
        send_word(make_matrix(e));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 600)
            begin
                in_valid <= 1'b0;
                burst_left = 0;
                @(negedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            send_word(rand_matrix());
        end
        in_valid <= 1'b0;

        @(negedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("[matrix3x3_inverse] OK");
        else
            $display("[matrix3x3_inverse] ERROR");
        $finish;
    end

endmodule
